@@ src/tccs_pkg.sv @@
// tccs_pkg: shared types and constants of the text console engine
// no dependencies
package tccs_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned IN_W   = 32;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 2'd2;

  // input action codes
  localparam logic [2:0] ACT_PUT  = 3'd0;
  localparam logic [2:0] ACT_MOVE = 3'd1;
  localparam logic [2:0] ACT_CLS  = 3'd2;
  localparam logic [2:0] ACT_CLR  = 3'd3;
  localparam logic [2:0] ACT_READ = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [3:0] FG_RESET = 4'd7;
  localparam logic [3:0] BG_RESET = 4'd0;
  localparam logic [CELL_W-1:0] CELL_RESET = {BG_RESET, FG_RESET, CH_SPACE};

  // classified command kinds
  localparam logic [3:0] K_NOP   = 4'd0;
  localparam logic [3:0] K_PRINT = 4'd1;
  localparam logic [3:0] K_NL    = 4'd2;
  localparam logic [3:0] K_CR    = 4'd3;
  localparam logic [3:0] K_BS    = 4'd4;
  localparam logic [3:0] K_MOVE  = 4'd5;
  localparam logic [3:0] K_CLS   = 4'd6;
  localparam logic [3:0] K_CLR   = 4'd7;
  localparam logic [3:0] K_READ  = 4'd8;

  typedef struct packed {
    logic [3:0]        kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row2;
  } cmd_t;

endpackage

@@ src/text_console_cursor_scroll.sv @@
// text_console_cursor_scroll: top level of the text console engine
// depends on tccs_pkg, tccs_front, tccs_back
//
// text console engine: a ROWS x COLUMNS screen of 16-bit cells (char in the low
// byte, attribute bg:fg in the high byte) plus a cursor, held in one ram with a
// single write and a single registered read port. after reset a clearing pass
// writes every cell, and no word is accepted until it ends. a front stage
// classifies and clamps each input word into a two-entry queue; a back stage
// executes it. printable characters, return, backspace, newline without scroll
// and cursor moves are done in the idle state, a cell read goes on through a
// read state for the registered ram read. clear screen, clearing rows and a
// scroll write cell by cell through the single ram write port; a scroll copies
// the rows below the region top up by one row and then blanks the last row.
// each word gives exactly one result word
module text_console_cursor_scroll #(
  parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // action[2:0], char_code[10:3], target_row[15:11], target_col[22:16],
  // bottom_row[27:23], zero fill above
  input  logic [tccs_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // row_now[4:0], col_now[11:5], read_char[19:12], read_attr[27:20], zero fill
  output logic [tccs_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccs_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [3:0]     fg_r, bg_r;
  logic [4:0]     top_r;
  logic           q_valid, pop, init_busy;
  tccs_pkg::cmd_t q_cmd;

  // config regs, unknown index ignored
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r  <= tccs_pkg::FG_RESET;
      bg_r  <= tccs_pkg::BG_RESET;
      top_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tccs_pkg::REG_FG:  fg_r  <= cfg_data[3:0];
        tccs_pkg::REG_BG:  bg_r  <= cfg_data[3:0];
        tccs_pkg::REG_TOP: top_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: decode and queue
  tccs_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .hold(init_busy), .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  // back: screen memory, cursor, result register
  tccs_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop), .init_busy(init_busy),
    .fg(fg_r), .bg(bg_r), .region_top(top_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

@@ src/tccs_ram.sv @@
// tccs_ram: generic single write port, single read port ram, registered read
// no dependencies
module tccs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/tccs_front.sv @@
// tccs_front: accepts input words, classifies and clamps them, two-entry queue
// depends on tccs_pkg
module tccs_front #(
  parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tccs_pkg::IN_W-1:0] in_tdata,
  input  logic                      hold,
  input  logic                      pop,
  output logic                      q_valid,
  output tccs_pkg::cmd_t            q_cmd
);

  localparam logic [tccs_pkg::ROW_W-1:0] ROW_MAX = tccs_pkg::ROW_W'(ROWS - 1);
  localparam logic [tccs_pkg::COL_W-1:0] COL_MAX = tccs_pkg::COL_W'(COLUMNS - 1);

  logic [2:0]                  act;
  logic [tccs_pkg::CHAR_W-1:0] ch;
  logic [tccs_pkg::ROW_W-1:0]  trow, brow, brow_c;
  logic [tccs_pkg::COL_W-1:0]  tcol;
  tccs_pkg::cmd_t              cmd;

  tccs_pkg::cmd_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push;

  assign act  = in_tdata[2:0];
  assign ch   = in_tdata[10:3];
  assign trow = in_tdata[15:11];
  assign tcol = in_tdata[22:16];
  assign brow = in_tdata[27:23];
  assign brow_c = (brow > ROW_MAX) ? ROW_MAX : brow;

  always_comb begin
    cmd.ch   = ch;
    cmd.row  = (trow > ROW_MAX) ? ROW_MAX : trow;
    cmd.col  = (tcol > COL_MAX) ? COL_MAX : tcol;
    cmd.row2 = brow_c;
    case (act)
      tccs_pkg::ACT_PUT: begin
        if (ch == tccs_pkg::CH_NEWLINE) cmd.kind = tccs_pkg::K_NL;
        else if (ch == tccs_pkg::CH_RETURN) cmd.kind = tccs_pkg::K_CR;
        else if (ch == tccs_pkg::CH_BACKSPACE) cmd.kind = tccs_pkg::K_BS;
        else cmd.kind = tccs_pkg::K_PRINT;
      end
      tccs_pkg::ACT_MOVE: cmd.kind = tccs_pkg::K_MOVE;
      tccs_pkg::ACT_CLS:  cmd.kind = tccs_pkg::K_CLS;
      // empty range when first row lies below the clamped last row
      tccs_pkg::ACT_CLR:  cmd.kind = (brow_c >= trow) ? tccs_pkg::K_CLR : tccs_pkg::K_NOP;
      tccs_pkg::ACT_READ: cmd.kind = tccs_pkg::K_READ;
      default:            cmd.kind = tccs_pkg::K_NOP;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2) && !hold;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_cmd     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/tccs_back.sv @@
// tccs_back: executes queued commands on the screen memory, owns cursor and result
// depends on tccs_pkg, tccs_ram
module tccs_back #(
  parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  tccs_pkg::cmd_t             q_cmd,
  output logic                       pop,
  output logic                       init_busy,
  input  logic [3:0]                 fg,
  input  logic [3:0]                 bg,
  input  logic [4:0]                 region_top,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [tccs_pkg::OUT_W-1:0] out_tdata
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [tccs_pkg::ROW_W-1:0] ROW_MAX = tccs_pkg::ROW_W'(ROWS - 1);
  localparam logic [tccs_pkg::COL_W-1:0] COL_MAX = tccs_pkg::COL_W'(COLUMNS - 1);
  localparam logic [AW:0]   SRC_END   = (AW+1)'(CELLS);
  localparam logic [AW-1:0] LAST_ROW0 = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SCROLL = 3'd2;
  localparam logic [2:0] S_FILL   = 3'd3;

  logic [2:0] state_r, state_nxt;
  logic [tccs_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [tccs_pkg::COL_W-1:0] col_r, col_nxt;
  logic [AW-1:0] fill_addr_r, fill_addr_nxt, fill_end_r, fill_end_nxt;
  logic          fill_init_r, fill_init_nxt;
  logic [AW:0]   src_r, src_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] wa_r, wa_nxt;

  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [tccs_pkg::CELL_W-1:0] wdata, rdata, blank;
  logic [4:0]             top_c;

  logic       ld;
  logic [7:0] ld_char, ld_attr;
  logic       out_valid_r;
  logic [tccs_pkg::OUT_W-1:0] out_data_r;

  function automatic logic [AW-1:0] cell_addr(input logic [tccs_pkg::ROW_W-1:0] r,
                                              input logic [tccs_pkg::COL_W-1:0] c);
    cell_addr = AW'(int'(r) * COLUMNS + int'(c));
  endfunction

  tccs_ram #(.WIDTH(tccs_pkg::CELL_W), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign blank = {bg, fg, tccs_pkg::CH_SPACE};
  assign top_c = (region_top > 5'(ROWS - 1)) ? 5'(ROWS - 1) : region_top;
  assign init_busy = fill_init_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    fill_addr_nxt = fill_addr_r;
    fill_end_nxt  = fill_end_r;
    fill_init_nxt = fill_init_r;
    src_nxt       = src_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    we      = 1'b0;
    waddr   = wa_r;
    wdata   = rdata;
    raddr   = cell_addr(q_cmd.row, q_cmd.col);
    pop     = 1'b0;
    ld      = 1'b0;
    ld_char = 8'd0;
    ld_attr = 8'd0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || out_tready)) begin
          pop = 1'b1;
          ld  = 1'b1;
          case (q_cmd.kind)
            tccs_pkg::K_PRINT, tccs_pkg::K_NL: begin
              if (q_cmd.kind == tccs_pkg::K_PRINT) begin
                we    = 1'b1;
                waddr = cell_addr(row_r, col_r);
                wdata = {bg, fg, q_cmd.ch};
              end
              if (q_cmd.kind == tccs_pkg::K_NL || col_r == COL_MAX) begin
                col_nxt = '0;
                if (row_r == ROW_MAX) begin
                  // scroll: copy rows below the region top up by one row
                  ld        = 1'b0;
                  src_nxt   = (AW+1)'((int'(top_c) + 1) * COLUMNS);
                  pend_nxt  = 1'b0;
                  state_nxt = S_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
              end
            end
            tccs_pkg::K_CR: col_nxt = '0;
            tccs_pkg::K_BS: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                we      = 1'b1;
                waddr   = cell_addr(row_r, col_r - 1'b1);
                wdata   = blank;
              end
            end
            tccs_pkg::K_MOVE: begin
              row_nxt = q_cmd.row;
              col_nxt = q_cmd.col;
            end
            tccs_pkg::K_CLS: begin
              ld            = 1'b0;
              row_nxt       = '0;
              col_nxt       = '0;
              fill_addr_nxt = '0;
              fill_end_nxt  = LAST_CELL;
              state_nxt     = S_FILL;
            end
            tccs_pkg::K_CLR: begin
              ld            = 1'b0;
              fill_addr_nxt = cell_addr(q_cmd.row, '0);
              fill_end_nxt  = cell_addr(q_cmd.row2, COL_MAX);
              state_nxt     = S_FILL;
            end
            tccs_pkg::K_READ: begin
              ld        = 1'b0;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ld        = 1'b1;
        ld_char   = rdata[7:0];
        ld_attr   = rdata[15:8];
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        we = pend_r;
        if (src_r < SRC_END) begin
          raddr    = src_r[AW-1:0];
          src_nxt  = src_r + 1'b1;
          pend_nxt = 1'b1;
          wa_nxt   = AW'(src_r - (AW+1)'(COLUMNS));
        end else begin
          pend_nxt      = 1'b0;
          fill_addr_nxt = LAST_ROW0;
          fill_end_nxt  = LAST_CELL;
          state_nxt     = S_FILL;
        end
      end
      S_FILL: begin
        we    = 1'b1;
        waddr = fill_addr_r;
        wdata = fill_init_r ? tccs_pkg::CELL_RESET : blank;
        fill_addr_nxt = fill_addr_r + 1'b1;
        if (fill_addr_r == fill_end_r) begin
          ld            = !fill_init_r;
          fill_init_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    wa_r  <= wa_nxt;
    if (ld) begin
      out_data_r <= {4'd0, ld_attr, ld_char, col_nxt, row_nxt};
    end
    if (!rst_n) begin
      state_r     <= S_FILL;
      row_r       <= '0;
      col_r       <= '0;
      fill_addr_r <= '0;
      fill_end_r  <= LAST_CELL;
      fill_init_r <= 1'b1;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_init_r <= fill_init_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= ld | (out_valid_r & ~out_tready);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/tccs_checker.sv @@
// tccs_checker: port-level assertions for the text console engine, bound to top
// depends on tccs_pkg, text_console_cursor_scroll
module tccs_checker #(
  parameter int unsigned COLUMNS = tccs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccs_pkg::ROWS_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [tccs_pkg::OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[4:0]) <= ROWS - 1))
    else $error("cursor row out of screen");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[11:5]) <= COLUMNS - 1))
    else $error("cursor column out of screen");

  a_no_accept_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted during clearing pass");

endmodule

bind text_console_cursor_scroll tccs_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tccs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/sv/text_console_cursor_scroll_chk.sv @@
// text_console_cursor_scroll_chk: watches the input, result and register channels,
// predicts each result word and compares it; depends on tccs_pkg
`timescale 1ns / 1ps
module text_console_cursor_scroll_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int NCOL = 80;
  localparam int NROW = 25;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] rch;
    logic [7:0] rattr;
  } console_result_t;

  logic [15:0]     screen [0:NROW*NCOL-1];
  int              cur_row, cur_col;
  logic [3:0]      fg, bg;
  logic [4:0]      top_row;
  console_result_t results_due [$];

  function automatic logic [15:0] blank_cell();
    return {bg, fg, tccs_pkg::CH_SPACE};
  endfunction

  task automatic blank_line(input int r);
    for (int x = 0; x < NCOL; x++) screen[r*NCOL+x] = blank_cell();
  endtask

  task automatic next_line();
    int t;
    cur_col = 0;
    cur_row++;
    if (cur_row >= NROW) begin
      t = (int'(top_row) > NROW-1) ? NROW-1 : int'(top_row);
      for (int y = t + 1; y < NROW; y++)
        for (int x = 0; x < NCOL; x++) screen[(y-1)*NCOL+x] = screen[y*NCOL+x];
      blank_line(NROW-1);
      cur_row = NROW-1;
      cur_col = 0;
    end
  endtask

  task automatic print_byte(input logic [7:0] ch);
    if (ch == tccs_pkg::CH_NEWLINE) begin
      next_line();
    end else if (ch == tccs_pkg::CH_RETURN) begin
      cur_col = 0;
    end else if (ch == tccs_pkg::CH_BACKSPACE) begin
      if (cur_col > 0) begin
        cur_col--;
        screen[cur_row*NCOL+cur_col] = blank_cell();
      end
    end else begin
      screen[cur_row*NCOL+cur_col] = {bg, fg, ch};
      cur_col++;
      if (cur_col >= NCOL) next_line();
    end
  endtask

  task automatic apply_word(input logic [31:0] w);
    logic [2:0]      act;
    int              tr, tc, br;
    logic [15:0]     cell_word;
    console_result_t res;
    act = w[2:0];
    tr = int'(w[15:11]);
    tc = int'(w[22:16]);
    br = int'(w[27:23]);
    res.rch = 8'd0;
    res.rattr = 8'd0;
    case (act)
      tccs_pkg::ACT_PUT: print_byte(w[10:3]);
      tccs_pkg::ACT_MOVE: begin
        cur_row = (tr > NROW-1) ? NROW-1 : tr;
        cur_col = (tc > NCOL-1) ? NCOL-1 : tc;
      end
      tccs_pkg::ACT_CLS: begin
        for (int y = 0; y < NROW; y++) blank_line(y);
        cur_row = 0;
        cur_col = 0;
      end
      tccs_pkg::ACT_CLR: begin
        if (br > NROW-1) br = NROW-1;
        if (br >= tr)
          for (int y = tr; y <= br; y++) blank_line(y);
      end
      tccs_pkg::ACT_READ: begin
        cell_word = screen[((tr > NROW-1) ? NROW-1 : tr)*NCOL + ((tc > NCOL-1) ? NCOL-1 : tc)];
        res.rch = cell_word[7:0];
        res.rattr = cell_word[15:8];
      end
      default: ;
    endcase
    res.row = cur_row[4:0];
    res.col = cur_col[6:0];
    results_due.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      // model state follows the block's reset
      errors = 0;
      pending = 0;
      fg = tccs_pkg::FG_RESET;
      bg = tccs_pkg::BG_RESET;
      top_row = '0;
      cur_row = 0;
      cur_col = 0;
      for (int i = 0; i < NROW*NCOL; i++) screen[i] = tccs_pkg::CELL_RESET;
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tccs_pkg::REG_FG:  fg = cfg_data[3:0];
          tccs_pkg::REG_BG:  bg = cfg_data[3:0];
          tccs_pkg::REG_TOP: top_row = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) apply_word(in_tdata);
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with nothing expected", $realtime);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (out_tdata[4:0] != want.row)
            report_mismatch("row_now", int'(out_tdata[4:0]), int'(want.row));
          if (out_tdata[11:5] != want.col)
            report_mismatch("col_now", int'(out_tdata[11:5]), int'(want.col));
          if (out_tdata[19:12] != want.rch)
            report_mismatch("read_char", int'(out_tdata[19:12]), int'(want.rch));
          if (out_tdata[27:20] != want.rattr)
            report_mismatch("read_attr", int'(out_tdata[27:20]), int'(want.rattr));
        end
      end
      pending = results_due.size();
    end
  end
endmodule

@@ tb/sv/text_console_cursor_scroll_tb.sv @@
// text_console_cursor_scroll_tb: stimulus, back-pressure and verdict for the console engine
// depends on tccs_pkg, text_console_cursor_scroll and text_console_cursor_scroll_chk
`timescale 1ns / 1ps
module text_console_cursor_scroll_tb;

  // longest quiet spell: a full clear or a scroll, plus the hold-off
  localparam int QUIET_LIMIT = 30000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  int          errors, pending;
  int          quiet = 0;
  bit          idle_free = 0;   // stretch with no gaps on either side
  bit          hold_req = 0;    // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  text_console_cursor_scroll i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  text_console_cursor_scroll_chk i_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // watchdog: cycles in which no channel moves a word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("text_console_cursor_scroll test failed");
      $finish;
    end
  end

  // receiver: random wait per word, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        w = idle_free ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_tready = 1'b0;
          repeat (w) @(negedge clk);
        end
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // fields packed from the lowest bit: action, char, row, col, bottom row
  function automatic logic [31:0] pack_word(logic [2:0] act, logic [7:0] ch, logic [4:0] r,
                                            logic [6:0] c, logic [4:0] br);
    return {4'd0, br, c, r, ch, act};
  endfunction

  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = w;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_put(input logic [7:0] ch);
    send_word(pack_word(tccs_pkg::ACT_PUT, ch, 5'($urandom), 7'($urandom), 5'($urandom)));
  endtask

  // mostly printable bytes, now and then a control byte, many moves and reads
  function automatic logic [31:0] random_word();
    int sel, k;
    logic [7:0] ch;
    logic [2:0] act;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      act = tccs_pkg::ACT_PUT;
      k = $urandom_range(0, 99);
      ch = (k < 3) ? tccs_pkg::CH_NEWLINE : (k < 6) ? tccs_pkg::CH_RETURN :
           (k < 11) ? tccs_pkg::CH_BACKSPACE : 8'($urandom);
      return pack_word(act, ch, 5'($urandom), 7'($urandom), 5'($urandom));
    end
    if (sel < 75)      act = tccs_pkg::ACT_MOVE;
    else if (sel < 76) act = tccs_pkg::ACT_CLS;
    else if (sel < 82) act = tccs_pkg::ACT_CLR;
    else if (sel < 96) act = tccs_pkg::ACT_READ;
    else               act = 3'($urandom_range(5, 7));
    return pack_word(act, 8'($urandom), 5'($urandom), 7'($urandom), 5'($urandom));
  endfunction

  initial begin
    logic [4:0] fg_set [5] = '{5'd15, 5'd0, 5'd31, 5'd16, 5'd9};
    logic [4:0] bg_set [5] = '{5'd15, 5'd0, 5'd16, 5'd31, 5'd3};
    logic [4:0] top_set[5] = '{5'd24, 5'd0, 5'd31, 5'd23, 5'd12};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed words on reset settings
    send_put(8'd0);
    send_put(8'd255);
    send_put("A");
    send_put(tccs_pkg::CH_BACKSPACE);
    send_put(tccs_pkg::CH_RETURN);
    send_put(tccs_pkg::CH_BACKSPACE);              // backspace at column zero
    send_put(tccs_pkg::CH_NEWLINE);
    send_word(pack_word(tccs_pkg::ACT_MOVE, 8'd0, 5'd31, 7'd127, 5'd0));  // clamped to corner
    send_put("Z");                                 // last column of the last row: wrap and scroll
    send_put(tccs_pkg::CH_NEWLINE);                // newline on the last row scrolls
    send_word(pack_word(tccs_pkg::ACT_MOVE, 8'd0, 5'd3, 7'd79, 5'd0));
    send_put("q");                                 // wrap at the last column, no scroll
    send_word(pack_word(tccs_pkg::ACT_READ, 8'd0, 5'd3, 7'd79, 5'd0));
    send_word(pack_word(tccs_pkg::ACT_READ, 8'd0, 5'd31, 7'd127, 5'd0));
    send_word(pack_word(tccs_pkg::ACT_READ, 8'd0, 5'd0, 7'd0, 5'd0));
    send_word(pack_word(tccs_pkg::ACT_CLR, 8'd0, 5'd10, 7'd0, 5'd5));  // bottom above first
    send_word(pack_word(tccs_pkg::ACT_CLR, 8'd0, 5'd31, 7'd0, 5'd31));
    send_word(pack_word(tccs_pkg::ACT_CLR, 8'd0, 5'd0, 7'd0, 5'd31));
    send_word(pack_word(3'd5, 8'hff, 5'd31, 7'd127, 5'd31));
    send_word(pack_word(3'd6, 8'd0, 5'd0, 7'd0, 5'd0));
    send_word(pack_word(3'd7, 8'h55, 5'd10, 7'd42, 5'd21));
    send_word(pack_word(tccs_pkg::ACT_CLS, 8'd0, 5'd0, 7'd0, 5'd0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(tccs_pkg::REG_FG, fg_set[ph]);
      write_reg(tccs_pkg::REG_BG, bg_set[ph]);
      write_reg(tccs_pkg::REG_TOP, top_set[ph]);
      if (ph == 3) write_reg(2'd3, 5'd31);         // unknown index is ignored
      for (int n = 0; n < 270; n++) begin
        if (n % 90 == 0) idle_free = ($urandom_range(0, 2) == 0);
        if (ph == 2 && n == 100) hold_req = 1;
        send_word(random_word());
      end
      idle_free = 0;
      drain();
    end

    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("text_console_cursor_scroll test passed");
    else
      $display("text_console_cursor_scroll test failed");
    $finish;
  end
endmodule
